@@ rtl/button_click_gesture_classifier_unit_defines.svh @@
// Assertion macros for the button click gesture classifier.
`ifndef BUTTON_CLICK_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_CLICK_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define BCGC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the block clock, off during reset
`define BCGC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bcgc_pkg.sv @@
// Types, constants and helpers shared by the click gesture classifier.
`default_nettype none
package bcgc_pkg;

   localparam int LED_COUNT  = 8;
   localparam int TIMER_BITS = 16;
   localparam int CSR_BITS   = 16;
   localparam int LED_BITS   = 8;   // width of the output pattern field
   localparam int CODE_BITS  = 3;
   localparam int CMP_BITS   = (TIMER_BITS > CSR_BITS) ? TIMER_BITS : CSR_BITS;

   localparam logic [CSR_BITS-1:0]   TIMEOUT_RESET = CSR_BITS'(1000);
   localparam logic [TIMER_BITS-1:0] TIMER_MAX     = {TIMER_BITS{1'b1}};
   localparam logic [LED_COUNT-1:0]  LED_MASK      = {LED_COUNT{1'b1}};
   localparam logic [LED_COUNT-1:0]  LED_LONG      = LED_COUNT'(8'h0F);
   localparam logic [LED_COUNT-1:0]  LED_SHORT_LONG = LED_COUNT'(8'h3F);
   localparam logic [LED_COUNT-1:0]  LED_OFF       = '0;

   // state codes as seen on the result port
   localparam logic [CODE_BITS-1:0] CODE_IDLE       = 3'd0;
   localparam logic [CODE_BITS-1:0] CODE_PRESSED    = 3'd1;
   localparam logic [CODE_BITS-1:0] CODE_SHORT_REL  = 3'd2;
   localparam logic [CODE_BITS-1:0] CODE_LONG_PRESS = 3'd3;
   localparam logic [CODE_BITS-1:0] CODE_LONG_REL   = 3'd4;
   localparam logic [CODE_BITS-1:0] CODE_DBL_SHORT  = 3'd5;
   localparam logic [CODE_BITS-1:0] CODE_DBL_LONG   = 3'd6;

   localparam logic [CODE_BITS-1:0] GEST_NONE = 3'd0;

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_PRESSED    = 7'b0000010,
      ST_SHORT_REL  = 7'b0000100,
      ST_LONG_PRESS = 7'b0001000,
      ST_LONG_REL   = 7'b0010000,
      ST_DBL_SHORT  = 7'b0100000,
      ST_DBL_LONG   = 7'b1000000
   } state_type;

   // action codes 1..6 double as gesture codes
   typedef enum logic [CODE_BITS-1:0] {
      ACT_NOP         = 3'd0,
      ACT_SHORT       = 3'd1,
      ACT_SHORT_SHORT = 3'd2,
      ACT_LONG        = 3'd3,
      ACT_SHORT_LONG  = 3'd4,
      ACT_LONG_SHORT  = 3'd5,
      ACT_LONG_LONG   = 3'd6,
      ACT_TSTART      = 3'd7
   } action_type;

   typedef struct packed {
      logic prs;   // press edge
      logic rls;   // release edge
      logic tmo;   // timeout
   } event_type;

   function automatic logic [CODE_BITS-1:0] state_code(input state_type s);
      logic [CODE_BITS-1:0] c;
      case (s)
         ST_IDLE:       c = CODE_IDLE;
         ST_PRESSED:    c = CODE_PRESSED;
         ST_SHORT_REL:  c = CODE_SHORT_REL;
         ST_LONG_PRESS: c = CODE_LONG_PRESS;
         ST_LONG_REL:   c = CODE_LONG_REL;
         ST_DBL_SHORT:  c = CODE_DBL_SHORT;
         ST_DBL_LONG:   c = CODE_DBL_LONG;
         default:       c = CODE_IDLE;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/bcgc_event.sv @@
// Edge detection, saturating tick counter and timeout event.
`default_nettype none
module bcgc_event import bcgc_pkg::*; (
   input  wire logic                  level,
   input  wire logic                  prev_level,
   input  wire state_type             state,
   input  wire logic [TIMER_BITS-1:0] elapsed,
   input  wire logic [CSR_BITS-1:0]   timeout,
   output event_type                  ev,
   output logic [TIMER_BITS-1:0]      cnt_inc
);

   logic timed;
   logic expired;

   always_comb begin
      cnt_inc = (elapsed == TIMER_MAX) ? elapsed : elapsed + 1'b1;
      expired = CMP_BITS'(cnt_inc) >= CMP_BITS'(timeout);
      timed   = !(state == ST_IDLE || state == ST_LONG_PRESS);
      ev.prs  = level && !prev_level;
      ev.rls  = !level && prev_level;
      ev.tmo  = (level == prev_level) && timed && expired;
   end

endmodule
`default_nettype wire

@@ rtl/bcgc_fsm.sv @@
// Seven-state click table and LED bar update.
`default_nettype none
module bcgc_fsm import bcgc_pkg::*; (
   input  wire state_type            state,
   input  wire event_type            ev,
   input  wire logic [LED_COUNT-1:0] led_bar,
   output state_type                 state_next,
   output logic [LED_COUNT-1:0]      led_next,
   output logic [CODE_BITS-1:0]      gesture,
   output logic                      timer_start
);

   action_type act;

   always_comb begin
      state_next = state;
      act        = ACT_NOP;
      case (state)
         ST_IDLE: begin
            if (ev.prs) begin
               state_next = ST_PRESSED;
               act        = ACT_TSTART;
            end
         end
         ST_PRESSED: begin
            if (ev.rls) begin
               state_next = ST_SHORT_REL;
               act        = ACT_TSTART;
            end else if (ev.tmo) begin
               state_next = ST_LONG_PRESS;
            end
         end
         ST_SHORT_REL: begin
            if (ev.prs) begin
               state_next = ST_DBL_SHORT;
               act        = ACT_TSTART;
            end else if (ev.tmo) begin
               state_next = ST_IDLE;
               act        = ACT_SHORT;
            end
         end
         ST_LONG_PRESS: begin
            if (ev.rls) begin
               state_next = ST_LONG_REL;
               act        = ACT_TSTART;
            end
         end
         ST_LONG_REL: begin
            if (ev.prs) begin
               state_next = ST_DBL_LONG;
               act        = ACT_TSTART;
            end else if (ev.tmo) begin
               state_next = ST_IDLE;
               act        = ACT_LONG;
            end
         end
         ST_DBL_SHORT: begin
            if (ev.rls) begin
               state_next = ST_IDLE;
               act        = ACT_SHORT_SHORT;
            end else if (ev.tmo) begin
               state_next = ST_IDLE;
               act        = ACT_SHORT_LONG;
            end
         end
         ST_DBL_LONG: begin
            if (ev.rls) begin
               state_next = ST_IDLE;
               act        = ACT_LONG_SHORT;
            end else if (ev.tmo) begin
               state_next = ST_IDLE;
               act        = ACT_LONG_LONG;
            end
         end
         default: begin
            // illegal encoding: recover to idle on any event
            if (ev.prs || ev.rls || ev.tmo) begin
               state_next = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      led_next = led_bar;
      case (act)
         ACT_SHORT: begin
            if (led_bar != LED_MASK) begin
               led_next = (led_bar << 1) | LED_COUNT'(1);
            end
         end
         ACT_SHORT_SHORT: led_next = led_bar >> 1;
         ACT_LONG:        led_next = LED_LONG;
         ACT_SHORT_LONG:  led_next = LED_SHORT_LONG;
         ACT_LONG_SHORT:  led_next = LED_MASK;
         ACT_LONG_LONG:   led_next = LED_OFF;
         default:         led_next = led_bar;
      endcase
   end

   assign timer_start = (act == ACT_TSTART);
   assign gesture = (act inside {[ACT_SHORT:ACT_LONG_LONG]}) ? CODE_BITS'(act) : GEST_NONE;

endmodule
`default_nettype wire

@@ rtl/button_click_gesture_classifier_unit.sv @@
// Top level of the button click gesture classifier.
//
// One item per sample tick carries the sampled button level. The block keeps
// the previous level to find press and release edges, and a saturating tick
// counter that a timeout compares against csr_wr_data (reset 1000 ticks).
// A seven-state table tells short, long and the four double-click gestures
// apart; each gesture updates an LED bar. Every tick yields exactly one
// result: the LED bar, the gesture seen on that tick (0 if none) and the
// classifier state afterward. An accepted item is held in the input
// register, is classified and moves to the result register when that
// register is free. Throughput is one item per cycle while rsp_ready stays
// high; the only feedback is the update of the state, previous level,
// counter and LED bar registers. Both channels stall cleanly: the input
// register can still take an item while a result waits, and ready falls
// only when both registers are occupied and rsp_ready is low.
// csr_wr_en writes the timeout; write it only when no item is in flight.
`default_nettype none
module button_click_gesture_classifier_unit import bcgc_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_button_level,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [LED_BITS-1:0]       rsp_led_pattern,
   output logic [CODE_BITS-1:0]      rsp_gesture,
   output logic [CODE_BITS-1:0]      rsp_click_state,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_BITS-1:0]  csr_wr_data
);

`include "button_click_gesture_classifier_unit_defines.svh"

   // config
   logic [CSR_BITS-1:0]   timeout_ff,    timeout_in;

   // input register
   logic                  in_valid_ff,   in_valid_in;
   logic                  in_level_ff,   in_level_in;

   // classifier state
   state_type             state_ff,      state_in;
   logic                  prev_level_ff, prev_level_in;
   logic [TIMER_BITS-1:0] elapsed_ff,    elapsed_in;
   logic [LED_COUNT-1:0]  led_ff,        led_in;

   // result register
   logic                  out_valid_ff,  out_valid_in;
   logic [LED_BITS-1:0]   out_led_ff,    out_led_in;
   logic [CODE_BITS-1:0]  out_gest_ff,   out_gest_in;
   logic [CODE_BITS-1:0]  out_state_ff,  out_state_in;

   event_type             ev;
   logic [TIMER_BITS-1:0] cnt_inc;
   state_type             state_next;
   logic [LED_COUNT-1:0]  led_next;
   logic [CODE_BITS-1:0]  gesture;
   logic                  timer_start;

   logic                  out_free;
   logic                  advance;   // item moves from input to result register
   logic                  req_take;

   bcgc_event u_event (
      .level      (in_level_ff),
      .prev_level (prev_level_ff),
      .state      (state_ff),
      .elapsed    (elapsed_ff),
      .timeout    (timeout_ff),
      .ev         (ev),
      .cnt_inc    (cnt_inc)
   );

   bcgc_fsm u_fsm (
      .state       (state_ff),
      .ev          (ev),
      .led_bar     (led_ff),
      .state_next  (state_next),
      .led_next    (led_next),
      .gesture     (gesture),
      .timer_start (timer_start)
   );

   always_comb begin
      out_free  = !out_valid_ff || rsp_ready;
      advance   = in_valid_ff && out_free;
      req_ready = !in_valid_ff || advance;
      req_take  = req_valid && req_ready;

      timeout_in    = csr_wr_en ? csr_wr_data : timeout_ff;

      in_valid_in   = req_take || (in_valid_ff && !advance);
      in_level_in   = req_take ? req_button_level : in_level_ff;

      state_in      = advance ? state_next : state_ff;
      prev_level_in = advance ? in_level_ff : prev_level_ff;
      elapsed_in    = advance ? (timer_start ? '0 : cnt_inc) : elapsed_ff;
      led_in        = advance ? led_next : led_ff;

      out_valid_in  = advance || (out_valid_ff && !rsp_ready);
      out_led_in    = advance ? LED_BITS'(led_next) : out_led_ff;
      out_gest_in   = advance ? gesture : out_gest_ff;
      out_state_in  = advance ? state_code(state_next) : out_state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         in_valid_ff   <= 1'b0;
         state_ff      <= ST_IDLE;
         prev_level_ff <= 1'b0;
         elapsed_ff    <= '0;
         led_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         timeout_ff    <= timeout_in;
         in_valid_ff   <= in_valid_in;
         state_ff      <= state_in;
         prev_level_ff <= prev_level_in;
         elapsed_ff    <= elapsed_in;
         led_ff        <= led_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_level_ff  <= in_level_in;
      out_led_ff   <= out_led_in;
      out_gest_ff  <= out_gest_in;
      out_state_ff <= out_state_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_led_pattern = out_led_ff;
   assign rsp_gesture     = out_gest_ff;
   assign rsp_click_state = out_state_ff;

   // every gesture finishes the sequence back in idle
   `BCGC_ASSERT_NOW(a_gesture_ends_idle, rsp_valid && (rsp_gesture != GEST_NONE), rsp_click_state == CODE_IDLE, "gesture reported outside idle")

   // classifier state only moves with an item
   `BCGC_ASSERT_NEXT(a_state_holds, !reset && !advance, $stable(state_ff) && $stable(led_ff), "state changed without an item")

   // tick counter only climbs or restarts
   `BCGC_ASSERT_NEXT(a_counter_mono, !reset && advance, (elapsed_ff == '0) || (elapsed_ff >= $past(elapsed_ff)), "tick counter went backward")

endmodule
`default_nettype wire
